@@ rtl/rhc_pkg.sv @@
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int RGB_W              = 8;
  localparam int HUE_W              = 15;
  localparam int SAT_W              = 13;
  localparam int HUE_FRAC_BITS_DEF  = 6;
  localparam int SAT_FRAC_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // Hexcone sector chosen by the largest channel
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Classified pixel, passed from the front end to the divider back end
  typedef struct packed {
    logic               chroma;  // delta is nonzero
    logic [RGB_W-1:0]   val;     // largest channel
    logic [RGB_W-1:0]   delta;   // largest minus smallest
    logic [RGB_W-1:0]   num;     // magnitude of the in-sector difference
    logic               neg;     // in-sector difference is negative
    sector_t            sector;
  } rhc_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rhc_q_status_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [RGB_W:0] div_step(input logic [RGB_W-1:0] rem,
                                              input logic             bit_in,
                                              input logic [RGB_W-1:0] dv);
    logic [RGB_W:0] trial;
    logic [RGB_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      div_step = {1'b1, diff[RGB_W-1:0]};
    end else begin
      div_step = {1'b0, trial[RGB_W-1:0]};
    end
  endfunction

endpackage

@@ rtl/rhc_front.sv @@
`timescale 1ns / 1ps
module rhc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [rhc_pkg::RGB_W-1:0]  in_red,
  input  logic [rhc_pkg::RGB_W-1:0]  in_green,
  input  logic [rhc_pkg::RGB_W-1:0]  in_blue,
  input  rhc_pkg::rhc_q_status_t     q_stat,
  output logic                       busy,
  output logic                       push,
  output rhc_pkg::rhc_item_t         item
);
  import rhc_pkg::*;

  logic              valid_r, valid_nxt;
  rhc_item_t         item_r, item_nxt;
  logic [RGB_W-1:0]  mx, mn, p, q;
  sector_t           sec;

  // Classify: largest, smallest, sector (red wins ties, then green)
  always_comb begin
    mx = (in_red > in_green) ? in_red : in_green;
    mx = (mx > in_blue) ? mx : in_blue;
    mn = (in_red < in_green) ? in_red : in_green;
    mn = (mn < in_blue) ? mn : in_blue;
    if (in_red == mx) begin
      sec = SEC_RED;
      p   = in_green;
      q   = in_blue;
    end else if (in_green == mx) begin
      sec = SEC_GREEN;
      p   = in_blue;
      q   = in_red;
    end else begin
      sec = SEC_BLUE;
      p   = in_red;
      q   = in_green;
    end
    item_nxt.val    = mx;
    item_nxt.delta  = mx - mn;
    item_nxt.chroma = (mx != mn);
    item_nxt.neg    = (p < q);
    item_nxt.num    = (p < q) ? (q - p) : (p - q);
    item_nxt.sector = sec;
  end

  assign push = valid_r & ~q_stat.full;
  assign busy = valid_r & q_stat.full;
  assign item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/rhc_queue.sv @@
`timescale 1ns / 1ps
module rhc_queue #(
  parameter int DEPTH = rhc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rhc_pkg::rhc_item_t      wr_item,
  input  logic                    pop,
  output rhc_pkg::rhc_q_status_t  q_stat,
  output rhc_pkg::rhc_item_t      rd_item
);
  import rhc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rhc_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign rd_item      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (count_r == '0 || count_r == CW'(DEPTH)))
    else $error("queue pointers disagree with count");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && q_stat.full))
    else $error("push into a full queue");
`endif

endmodule

@@ rtl/rhc_back.sv @@
`timescale 1ns / 1ps
module rhc_back #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  rhc_pkg::rhc_item_t         in_item,
  output logic                       out_strobe,
  output logic [rhc_pkg::HUE_W-1:0]  out_hue,
  output logic [rhc_pkg::SAT_W-1:0]  out_sat,
  output logic [rhc_pkg::RGB_W-1:0]  out_val
);
  import rhc_pkg::*;

  localparam int QS  = SAT_FRAC_BITS + 1;
  localparam int QH  = HUE_FRAC_BITS + 6;
  localparam int Q   = (QS > QH) ? QS : QH;
  localparam int NW  = RGB_W + Q;
  localparam int HBW = HUE_FRAC_BITS + 10;
  localparam int HCW = (HBW > HUE_W) ? HBW : HUE_W;
  localparam int SCW = (Q > SAT_W) ? Q : SAT_W;

  logic [NW-1:0]    sat_num, hue_prod, hue_num;

  logic             valid_r    [0:Q];
  logic             valid_nxt  [0:Q];
  logic [RGB_W-1:0] sat_rem_r  [0:Q];
  logic [RGB_W-1:0] sat_rem_nxt[0:Q];
  logic [Q-1:0]     sat_low_r  [0:Q];
  logic [Q-1:0]     sat_low_nxt[0:Q];
  logic [RGB_W-1:0] hue_rem_r  [0:Q];
  logic [RGB_W-1:0] hue_rem_nxt[0:Q];
  logic [Q-1:0]     hue_low_r  [0:Q];
  logic [Q-1:0]     hue_low_nxt[0:Q];
  logic [RGB_W-1:0] sdiv_r     [0:Q];
  logic [RGB_W-1:0] sdiv_nxt   [0:Q];
  logic [RGB_W-1:0] hdiv_r     [0:Q];
  logic [RGB_W-1:0] hdiv_nxt   [0:Q];
  logic [RGB_W-1:0] val_r      [0:Q];
  logic [RGB_W-1:0] val_nxt    [0:Q];
  logic             neg_r      [0:Q];
  logic             neg_nxt    [0:Q];
  sector_t          sec_r      [0:Q];
  sector_t          sec_nxt    [0:Q];

  logic             out_strobe_r;
  logic [HUE_W-1:0] out_hue_r, out_hue_nxt;
  logic [SAT_W-1:0] out_sat_r, out_sat_nxt;
  logic [RGB_W-1:0] out_val_r;
  logic [HCW-1:0]   hue_base, hue_full;
  logic [SCW-1:0]   sat_ext;

  // Entry stage: numerators; 60*2^H*num as a difference of two shifts,
  // plus delta-1 for a negative offset so that the divide rounds up
  always_comb begin
    sat_num  = NW'(in_item.delta) << SAT_FRAC_BITS;
    hue_prod = (NW'(in_item.num) << (HUE_FRAC_BITS + 6))
             - (NW'(in_item.num) << (HUE_FRAC_BITS + 2));
    hue_num  = in_item.neg ? (hue_prod + NW'(in_item.delta) - NW'(1)) : hue_prod;
    valid_nxt[0]   = in_valid;
    sat_rem_nxt[0] = sat_num[NW-1:Q];
    sat_low_nxt[0] = sat_num[Q-1:0];
    hue_rem_nxt[0] = hue_num[NW-1:Q];
    hue_low_nxt[0] = hue_num[Q-1:0];
    // a grey or black pixel has zero numerators; keep the divisors nonzero
    sdiv_nxt[0]    = in_item.chroma ? in_item.val : RGB_W'(1);
    hdiv_nxt[0]    = in_item.chroma ? in_item.delta : RGB_W'(1);
    val_nxt[0]     = in_item.val;
    neg_nxt[0]     = in_item.neg;
    sec_nxt[0]     = in_item.sector;
  end

  genvar s;
  generate
    for (s = 1; s <= Q; s++) begin : g_div
      logic [RGB_W:0] sat_step, hue_step;
      assign sat_step = div_step(sat_rem_r[s-1], sat_low_r[s-1][Q-1], sdiv_r[s-1]);
      assign hue_step = div_step(hue_rem_r[s-1], hue_low_r[s-1][Q-1], hdiv_r[s-1]);
      assign valid_nxt[s]   = valid_r[s-1];
      assign sat_rem_nxt[s] = sat_step[RGB_W-1:0];
      assign sat_low_nxt[s] = {sat_low_r[s-1][Q-2:0], sat_step[RGB_W]};
      assign hue_rem_nxt[s] = hue_step[RGB_W-1:0];
      assign hue_low_nxt[s] = {hue_low_r[s-1][Q-2:0], hue_step[RGB_W]};
      assign sdiv_nxt[s]    = sdiv_r[s-1];
      assign hdiv_nxt[s]    = hdiv_r[s-1];
      assign val_nxt[s]     = val_r[s-1];
      assign neg_nxt[s]     = neg_r[s-1];
      assign sec_nxt[s]     = sec_r[s-1];
    end

    for (s = 0; s <= Q; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else begin
          valid_r[s] <= valid_nxt[s];
        end
      end

      always_ff @(posedge clk) begin
        sat_rem_r[s] <= sat_rem_nxt[s];
        sat_low_r[s] <= sat_low_nxt[s];
        hue_rem_r[s] <= hue_rem_nxt[s];
        hue_low_r[s] <= hue_low_nxt[s];
        sdiv_r[s]    <= sdiv_nxt[s];
        hdiv_r[s]    <= hdiv_nxt[s];
        val_r[s]     <= val_nxt[s];
        neg_r[s]     <= neg_nxt[s];
        sec_r[s]     <= sec_nxt[s];
      end
    end
  endgenerate

  // Exit stage: add the sector base, wrap negative offsets by a full circle
  always_comb begin
    case (sec_r[Q])
      SEC_RED:   hue_base = '0;
      SEC_GREEN: hue_base = HCW'(120) << HUE_FRAC_BITS;
      SEC_BLUE:  hue_base = HCW'(240) << HUE_FRAC_BITS;
      default:   hue_base = '0;
    endcase
    if (neg_r[Q]) begin
      hue_full = hue_base + (HCW'(360) << HUE_FRAC_BITS) - HCW'(hue_low_r[Q]);
    end else begin
      hue_full = hue_base + HCW'(hue_low_r[Q]);
    end
    sat_ext     = SCW'(sat_low_r[Q]);
    out_hue_nxt = hue_full[HUE_W-1:0];
    out_sat_nxt = sat_ext[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= valid_r[Q];
    end
  end

  always_ff @(posedge clk) begin
    out_hue_r <= out_hue_nxt;
    out_sat_r <= out_sat_nxt;
    out_val_r <= val_r[Q];
  end

  assign out_strobe = out_strobe_r;
  assign out_hue    = out_hue_r;
  assign out_sat    = out_sat_r;
  assign out_val    = out_val_r;

endmodule

@@ rtl/rgb_to_hsv_convert.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                   Handshake
// request   in_red, in_green, in_blue               taken when start high and busy low
// result    out_hue, out_saturation, out_value      valid for the one cycle out_strobe is high
//
// One request is taken every clock while busy is low. A result passes the front
// register, the queue, the divider entry stage, Q divide steps and the output
// register, Q = max(SAT_FRAC_BITS+1, HUE_FRAC_BITS+6), i.e. 13 at default.
// Synchronous active-low reset empties the front register, queue and pipeline.
// The receiver cannot stall and the back end pops the queue every cycle, so
// with QUEUE_DEPTH of two or more the queue never fills and busy stays low.
module rgb_to_hsv_convert #(
  parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH   = rhc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rhc_pkg::RGB_W-1:0]  in_red,
  input  logic [rhc_pkg::RGB_W-1:0]  in_green,
  input  logic [rhc_pkg::RGB_W-1:0]  in_blue,
  output logic                       out_strobe,
  output logic [rhc_pkg::HUE_W-1:0]  out_hue,
  output logic [rhc_pkg::SAT_W-1:0]  out_saturation,
  output logic [rhc_pkg::RGB_W-1:0]  out_value
);
  import rhc_pkg::*;

  localparam int QS  = SAT_FRAC_BITS + 1;
  localparam int QH  = HUE_FRAC_BITS + 6;
  localparam int Q   = (QS > QH) ? QS : QH;
  localparam int LAT = Q + 4;

  logic           accept;
  logic           push;
  rhc_item_t      front_item;
  rhc_item_t      head_item;
  rhc_q_status_t  q_stat;

  // Take a request whenever the front register can hand its pixel on
  assign accept = start & ~busy;

  // Front: register and classify the pixel (max, min, sector, sign)
  rhc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .item     (front_item)
  );

  // Short queue decoupling classification from the divider pipeline
  rhc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (q_stat.valid),
    .q_stat  (q_stat),
    .rd_item (head_item)
  );

  // Back: pipelined saturation and hue dividers, sector base and wrap
  rhc_back #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_stat.valid),
    .in_item    (head_item),
    .out_strobe (out_strobe),
    .out_hue    (out_hue),
    .out_sat    (out_saturation),
    .out_val    (out_value)
  );

`ifndef SYNTHESIS
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("request produced no result at the expected cycle");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result strobe without a matching request");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised although the back end drains every cycle");
`endif

endmodule
